>>> src/ole_pkg.sv
`default_nettype none

package ole_pkg;

	localparam int OPCODE_W    = 4;
	localparam int IN_VALUE_W  = 32;
	localparam int POS_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int OUT_VALUE_W = 32;
	localparam int FIDX_W      = 4;
	localparam int COUNT_OUT_W = 5;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 4'd0;
	localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 4'd1;
	localparam logic [OPCODE_W-1:0] OP_INS_POS   = 4'd2;
	localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 4'd3;
	localparam logic [OPCODE_W-1:0] OP_REM_BACK  = 4'd4;
	localparam logic [OPCODE_W-1:0] OP_REM_POS   = 4'd5;
	localparam logic [OPCODE_W-1:0] OP_FIND      = 4'd6;
	localparam logic [OPCODE_W-1:0] OP_READ_IDX  = 4'd7;
	localparam logic [OPCODE_W-1:0] OP_HEAD      = 4'd8;
	localparam logic [OPCODE_W-1:0] OP_CLEAR     = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic ins;
		logic rem;
		logic find;
		logic rd;
	} cell_cmd_t;

	typedef struct packed {
		logic go;
		logic found;
	} probe_t;

endpackage

`default_nettype wire

>>> src/ole_cell.sv
`default_nettype none

module ole_cell
	import ole_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5,
	parameter int INDEX       = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cell_cmd_t              cmd,
	input  wire logic [IDX_W-1:0]       shift_idx,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic [POS_W-1:0]       position,
	input  wire logic [VALUE_WIDTH-1:0] key,
	input  wire logic [VALUE_WIDTH-1:0] left_val,
	input  wire logic [VALUE_WIDTH-1:0] right_val,
	output logic [VALUE_WIDTH-1:0]      val,
	input  wire probe_t                 probe_in,
	input  wire logic [VALUE_WIDTH-1:0] probe_val_in,
	input  wire logic [IDX_W-1:0]       probe_idx_in,
	output probe_t                      probe_out,
	output logic [VALUE_WIDTH-1:0]      probe_val_out,
	output logic [IDX_W-1:0]            probe_idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
	localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

	logic [VALUE_WIDTH-1:0] val_q;
	probe_t                 probe_q;
	logic [VALUE_WIDTH-1:0] probe_val_q;
	logic [IDX_W-1:0]       probe_idx_q;
	logic                   in_list;
	logic                   hit;

	assign in_list = MY_CNT < count;
	assign hit     = in_list && ((cmd.find && (val_q == key)) ||
		(cmd.rd && (position == MY_POS)));

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX > shift_idx) begin
				val_q <= left_val;
			end else if (MY_IDX == shift_idx) begin
				val_q <= key;
			end
		end else if (cmd.rem) begin
			if (MY_IDX >= shift_idx) begin
				val_q <= right_val;
			end
		end
	end

	// The probe visits one cell per cycle and keeps the first hit it sees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.go    <= probe_in.go;
			probe_q.found <= probe_in.go && (probe_in.found || hit);
		end
	end

	always_ff @(posedge clk) begin
		if (probe_in.go) begin
			if (!probe_in.found && hit) begin
				probe_val_q <= val_q;
				probe_idx_q <= MY_IDX;
			end else begin
				probe_val_q <= probe_val_in;
				probe_idx_q <= probe_idx_in;
			end
		end
	end

	assign val           = val_q;
	assign probe_out     = probe_q;
	assign probe_val_out = probe_val_q;
	assign probe_idx_out = probe_idx_q;

endmodule

`default_nettype wire

>>> src/ordered_list_engine.sv
// Bounded ordered list of up to CAPACITY signed values, held as a row of cells, one entry per
// cell, with index 0 at the front. Each request beat carries an opcode, a value and a position,
// and each one yields exactly one result beat with a status, a read value, a found index and the
// count after the request. Inserts, removes, head reads, clears and unused opcodes go through these
// steps: the request is registered; for inserts and removes, every cell from the affected index on
// loads from its neighbor or the new value at once; the result is staged. Find and read by index
// send a probe down the row, one cell per cycle. The block works on one request at a time; the
// next one is taken while the previous result waits.
`default_nettype none

module ordered_list_engine
	import ole_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// opcode[3:0], item_value[35:4], position[43:36], zero fill above
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// status[2:0], read_value[34:3], found_index[38:35], entry_count[43:39], zero fill above
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0]             state_q;
	logic [OPCODE_W-1:0]    req_op_q;
	logic [VALUE_WIDTH-1:0] req_val_q;
	logic [POS_W-1:0]       req_pos_q;
	logic [CNT_W-1:0]       count_q;

	logic [STATUS_W-1:0]    res_status_q;
	logic [OUT_VALUE_W-1:0] res_value_q;
	logic [FIDX_W-1:0]      res_index_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                   in_fire;
	logic                   out_free;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       cnt_ext;

	logic [STATUS_W-1:0]    nx_status;
	logic [OUT_VALUE_W-1:0] nx_value;
	logic [CNT_W-1:0]       nx_count;
	logic                   do_ins;
	logic                   do_rem;
	logic                   do_scan;
	logic [IDX_W-1:0]       shift_idx;
	cell_cmd_t              cmd;

	logic [VALUE_WIDTH-1:0] cell_val     [CAPACITY];
	logic [VALUE_WIDTH-1:0] left_val     [CAPACITY];
	logic [VALUE_WIDTH-1:0] right_val    [CAPACITY];
	probe_t                 pin          [CAPACITY];
	logic [VALUE_WIDTH-1:0] pin_val      [CAPACITY];
	logic [IDX_W-1:0]       pin_idx      [CAPACITY];
	probe_t                 pout         [CAPACITY];
	logic [VALUE_WIDTH-1:0] pout_val     [CAPACITY];
	logic [IDX_W-1:0]       pout_idx     [CAPACITY];

	probe_t                 tail;
	logic                   is_find;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign pos_ext  = CMP_W'(req_pos_q);
	assign cnt_ext  = CMP_W'(count_q);
	assign tail     = pout[CAPACITY-1];
	assign is_find  = (req_op_q == OP_FIND);

	always_comb begin
		nx_status = ST_OK;
		nx_value  = '0;
		nx_count  = count_q;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		do_scan   = 1'b0;
		shift_idx = '0;
		unique case (req_op_q)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				if (count_q >= CNT_FULL) begin
					nx_status = ST_FULL;
				end else if (req_op_q == OP_INS_FRONT) begin
					do_ins = 1'b1;
				end else if (req_op_q == OP_INS_BACK) begin
					do_ins    = 1'b1;
					shift_idx = IDX_W'(count_q);
				end else if (pos_ext > cnt_ext) begin
					nx_status = ST_BADPOS;
				end else begin
					do_ins    = 1'b1;
					shift_idx = IDX_W'(req_pos_q);
				end
				if (do_ins) begin
					nx_count = count_q + CNT_ONE;
				end
			end
			OP_REM_FRONT, OP_REM_BACK, OP_REM_POS: begin
				if (count_q == '0) begin
					nx_status = ST_EMPTY;
				end else if (req_op_q == OP_REM_FRONT) begin
					do_rem = 1'b1;
				end else if (req_op_q == OP_REM_BACK) begin
					do_rem    = 1'b1;
					shift_idx = IDX_W'(count_q - CNT_ONE);
				end else if (pos_ext >= cnt_ext) begin
					nx_status = ST_BADPOS;
				end else begin
					do_rem    = 1'b1;
					shift_idx = IDX_W'(req_pos_q);
				end
				if (do_rem) begin
					nx_count = count_q - CNT_ONE;
				end
			end
			OP_FIND, OP_READ_IDX: begin
				do_scan = 1'b1;
			end
			OP_HEAD: begin
				if (count_q == '0) begin
					nx_status = ST_EMPTY;
				end else begin
					nx_value = OUT_VALUE_W'($signed(cell_val[0]));
				end
			end
			OP_CLEAR: begin
				nx_count = '0;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ins  = (state_q == S_EXEC) && do_ins;
	assign cmd.rem  = (state_q == S_EXEC) && do_rem;
	assign cmd.find = is_find;
	assign cmd.rd   = (req_op_q == OP_READ_IDX);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign left_val[gi] = '0;
				assign pin[gi].go    = (state_q == S_EXEC) && do_scan;
				assign pin[gi].found = 1'b0;
				assign pin_val[gi]   = '0;
				assign pin_idx[gi]   = '0;
			end else begin : g_link
				assign left_val[gi] = cell_val[gi-1];
				assign pin[gi]      = pout[gi-1];
				assign pin_val[gi]  = pout_val[gi-1];
				assign pin_idx[gi]  = pout_idx[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_end
				assign right_val[gi] = cell_val[gi];
			end else begin : g_mid
				assign right_val[gi] = cell_val[gi+1];
			end

			ole_cell #(
				.VALUE_WIDTH (VALUE_WIDTH),
				.IDX_W       (IDX_W),
				.CNT_W       (CNT_W),
				.INDEX       (gi)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.cmd           (cmd),
				.shift_idx     (shift_idx),
				.count         (count_q),
				.position      (req_pos_q),
				.key           (req_val_q),
				.left_val      (left_val[gi]),
				.right_val     (right_val[gi]),
				.val           (cell_val[gi]),
				.probe_in      (pin[gi]),
				.probe_val_in  (pin_val[gi]),
				.probe_idx_in  (pin_idx[gi]),
				.probe_out     (pout[gi]),
				.probe_val_out (pout_val[gi]),
				.probe_idx_out (pout_idx[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_scan) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_HOLD;
						count_q <= nx_count;
					end
				end
				S_SCAN: begin
					if (tail.go) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_op_q  <= s_tdata[OPCODE_W-1:0];
			req_val_q <= VALUE_WIDTH'($signed(s_tdata[OPCODE_W +: IN_VALUE_W]));
			req_pos_q <= s_tdata[OPCODE_W+IN_VALUE_W +: POS_W];
		end
		if ((state_q == S_EXEC) && !do_scan) begin
			res_status_q <= nx_status;
			res_value_q  <= nx_value;
			res_index_q  <= '0;
		end else if ((state_q == S_SCAN) && tail.go) begin
			if (is_find) begin
				res_status_q <= tail.found ? ST_OK : ST_NOTFOUND;
				res_value_q  <= '0;
				res_index_q  <= tail.found ? FIDX_W'(pout_idx[CAPACITY-1]) : '0;
			end else begin
				res_status_q <= tail.found ? ST_OK : ST_BADPOS;
				res_value_q  <= tail.found ?
					OUT_VALUE_W'($signed(pout_val[CAPACITY-1])) : '0;
				res_index_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_HOLD) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_HOLD) && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({COUNT_OUT_W'(count_q), res_index_q, res_value_q,
				res_status_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count exceeds capacity");

	a_probe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.go |-> (state_q == S_SCAN))
		else $error("probe left the cell row outside a scan");

	a_result_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_HOLD))
		else $error("result beat raised without a staged result");

	a_count_stable_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> $stable(count_q))
		else $error("entry count changed during a scan");

endmodule

`default_nettype wire
